FILE: hw/rtl/running_mean_variance_min_max_assert.svh
// Assertion macros for the running statistics block.
// Used by the checker module only.
`ifndef RUNNING_MEAN_VARIANCE_MIN_MAX_ASSERT_SVH
`define RUNNING_MEAN_VARIANCE_MIN_MAX_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define RMV_ASSERT_IMP(label, clk, rstn, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define RMV_ASSERT_NXT(label, clk, rstn, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: hw/rtl/rmv_pkg.sv
// Package for the running statistics block: payload structs, state codes
// and the command and status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rmv_pkg;

    // Fixed widths of the statistics.
    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 16;
    localparam int FRAC_BITS   = 8;

    // Input word.
    typedef struct packed {
        logic        op;
        logic [15:0] sample;
    } rmv_in_t;

    // Result word.
    typedef struct packed {
        logic [15:0] count;
        logic [31:0] total;
        logic [45:0] sum_of_squares;
        logic [23:0] mean_q8;
        logic [38:0] variance_q8;
        logic [23:0] std_dev_q8;
        logic [15:0] minimum;
        logic [15:0] maximum;
        logic        variance_valid;
        logic        dropped;
    } rmv_out_t;

    localparam logic OP_ACCUMULATE = 1'b0;
    localparam logic OP_CLEAR      = 1'b1;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SQUARE,
        ST_PREP,
        ST_MEAN,
        ST_VPREP,
        ST_VAR,
        ST_ROOT,
        ST_DONE
    } rmv_state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;
        logic update;
        logic square;
        logic prep;
        logic mean_step;
        logic vprep;
        logic var_step;
        logic root_step;
        logic publish;
    } rmv_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic mean_last;
        logic var_skip;
        logic var_last;
        logic root_last;
        logic stat_skip;
    } rmv_sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/rmv_ctrl.sv
// Controller state machine for the running statistics block.
// Depends on rmv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rmv_ctrl (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               start,
    input  wire               out_free,
    input  rmv_pkg::rmv_sts_t sts,
    output logic              busy,
    output rmv_pkg::rmv_cmd_t cmd
);
    import rmv_pkg::*;

    rmv_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    cmd.load = 1'b1;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_PREP;
            end
            ST_PREP: begin
                cmd.prep = 1'b1;
                state_next = sts.stat_skip ? ST_DONE : ST_MEAN;
            end
            ST_MEAN: begin
                cmd.mean_step = 1'b1;
                if (sts.mean_last) begin
                    state_next = ST_VPREP;
                end
            end
            ST_VPREP: begin
                cmd.vprep = 1'b1;
                state_next = sts.var_skip ? ST_DONE : ST_VAR;
            end
            ST_VAR: begin
                cmd.var_step = 1'b1;
                if (sts.var_last) begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                if (sts.root_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.publish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

FILE: hw/rtl/rmv_dpath.sv
// Datapath for the running statistics block: accumulators, extremes, a
// restoring divider for mean and variance, and a bit-serial square root.
// Depends on rmv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rmv_dpath (
    input  wire               aclk,
    input  wire               aresetn,
    input  rmv_pkg::rmv_in_t  in_word,
    input  rmv_pkg::rmv_cmd_t cmd,
    output rmv_pkg::rmv_sts_t sts,
    output rmv_pkg::rmv_out_t out_word
);
    import rmv_pkg::*;

    localparam int SQ_BITS  = 2 * SAMPLE_BITS;
    localparam int S2_BITS  = SQ_BITS + COUNT_BITS;
    localparam int S1_BITS  = SAMPLE_BITS + COUNT_BITS;
    localparam int DEN_BITS = 2 * COUNT_BITS;
    // Variance numerator n*S2 shifted by the fraction.
    localparam int TRM_BITS = S2_BITS + COUNT_BITS;
    localparam int NUM_BITS = TRM_BITS + FRAC_BITS;
    localparam int MN_BITS  = S1_BITS + FRAC_BITS;
    localparam int STEP_W   = $clog2(NUM_BITS + 1);
    localparam int RT_IN    = 2 * 24;
    localparam int RT_STEPS = 24;
    localparam int RT_W     = $clog2(RT_STEPS + 1);
    localparam logic [COUNT_BITS-1:0] CNT_FULL = '1;

    // Statistics state.
    logic [COUNT_BITS-1:0]  cnt_reg;
    logic signed [S1_BITS-1:0] s1_reg;
    logic [S2_BITS-1:0]     s2_reg;
    logic signed [SAMPLE_BITS-1:0] lo_reg, hi_reg;
    logic                   first_reg;
    logic                   op_reg, drop_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic [SQ_BITS-1:0]     sq_reg;

    // Division and root working registers.
    logic [NUM_BITS-1:0]    num_reg;
    logic [DEN_BITS:0]      rem_reg;
    logic [DEN_BITS-1:0]    den_reg;
    logic [STEP_W-1:0]      step_reg;
    logic                   neg_reg;
    logic [23:0]            mean_reg;
    logic [38:0]            var_reg;
    logic                   valid_reg;
    logic [RT_IN-1:0]       rx_reg;
    logic [25:0]            rrem_reg;
    logic [23:0]            root_reg;
    logic [RT_W-1:0]        rstep_reg;
    logic [S1_BITS-1:0]     ms_reg;
    logic [TRM_BITS-1:0]    a_reg;
    rmv_out_t               res_reg;

    logic [SAMPLE_BITS-1:0] mag;
    logic [DEN_BITS:0]      rem_sh;
    logic [DEN_BITS+1:0]    rem_dif;
    logic [25:0]            rt_sh;
    logic [25:0]            rt_try;
    logic [TRM_BITS-1:0]    b_val;

    assign mag = x_reg[SAMPLE_BITS-1] ? SAMPLE_BITS'(-x_reg) : x_reg;

    // Accumulators, extremes and first-sample flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            s1_reg    <= '0;
            s2_reg    <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            first_reg <= 1'b1;
        end else if (cmd.update) begin
            if (op_reg == OP_CLEAR) begin
                cnt_reg   <= '0;
                s1_reg    <= '0;
                s2_reg    <= '0;
                lo_reg    <= '0;
                hi_reg    <= '0;
                first_reg <= 1'b1;
            end else if (!drop_reg) begin
                cnt_reg   <= cnt_reg + 1'b1;
                s1_reg    <= s1_reg + S1_BITS'(x_reg);
                s2_reg    <= s2_reg + S2_BITS'(sq_reg);
                first_reg <= 1'b0;
                if (first_reg || x_reg < lo_reg) begin
                    lo_reg <= x_reg;
                end
                if (first_reg || x_reg > hi_reg) begin
                    hi_reg <= x_reg;
                end
            end
        end
    end

    // Captured input word and its square.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= in_word.op;
            x_reg    <= in_word.sample[SAMPLE_BITS-1:0];
            drop_reg <= (in_word.op == OP_ACCUMULATE) && (cnt_reg == CNT_FULL);
        end
        if (cmd.square) begin
            sq_reg <= SQ_BITS'(mag) * SQ_BITS'(mag);
        end
    end

    // Restoring divider step: shift one numerator bit into the remainder.
    assign rem_sh  = {rem_reg[DEN_BITS-1:0], num_reg[NUM_BITS-1]};
    assign rem_dif = {1'b0, rem_sh} - {2'b0, den_reg};
    assign b_val   = TRM_BITS'(ms_reg) * TRM_BITS'(ms_reg);

    // Root step: two radicand bits per cycle.
    assign rt_sh  = {rrem_reg[23:0], rx_reg[RT_IN-1 -: 2]};
    assign rt_try = {root_reg, 2'b01};

    assign sts.stat_skip = (cnt_reg == '0);
    assign sts.mean_last = (step_reg == STEP_W'(MN_BITS - 1));
    assign sts.var_skip  = (cnt_reg < COUNT_BITS'(2)) || (a_reg < b_val);
    assign sts.var_last  = (step_reg == STEP_W'(NUM_BITS - 1));
    assign sts.root_last = (rstep_reg == RT_W'(RT_STEPS - 1));

    // Division and root sequencing.
    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            neg_reg   <= s1_reg[S1_BITS-1];
            ms_reg    <= s1_reg[S1_BITS-1] ? S1_BITS'(-s1_reg) : S1_BITS'(s1_reg);
            num_reg   <= NUM_BITS'({(s1_reg[S1_BITS-1] ? S1_BITS'(-s1_reg)
                                     : S1_BITS'(s1_reg)), {FRAC_BITS{1'b0}}})
                         << (NUM_BITS - MN_BITS);
            den_reg   <= DEN_BITS'(cnt_reg);
            rem_reg   <= '0;
            step_reg  <= '0;
            a_reg     <= TRM_BITS'(cnt_reg) * TRM_BITS'(s2_reg);
            mean_reg  <= '0;
            var_reg   <= '0;
            valid_reg <= 1'b0;
        end
        if (cmd.load) begin
            mean_reg  <= '0;
            var_reg   <= '0;
            valid_reg <= 1'b0;
            root_reg  <= '0;
        end
        if (cmd.mean_step || cmd.var_step) begin
            step_reg <= step_reg + 1'b1;
            num_reg  <= {num_reg[NUM_BITS-2:0], ~rem_dif[DEN_BITS+1]};
            rem_reg  <= rem_dif[DEN_BITS+1] ? rem_sh : rem_dif[DEN_BITS:0];
        end
        if (cmd.mean_step && sts.mean_last) begin
            mean_reg <= neg_reg ? 24'(-{num_reg[NUM_BITS-2:0], ~rem_dif[DEN_BITS+1]})
                                : 24'({num_reg[NUM_BITS-2:0], ~rem_dif[DEN_BITS+1]});
        end
        if (cmd.vprep) begin
            num_reg  <= NUM_BITS'({a_reg - b_val, {FRAC_BITS{1'b0}}});
            den_reg  <= DEN_BITS'(cnt_reg) * DEN_BITS'(cnt_reg - 1'b1);
            rem_reg  <= '0;
            step_reg <= '0;
        end
        if (cmd.var_step && sts.var_last) begin
            var_reg   <= 39'({num_reg[NUM_BITS-2:0], ~rem_dif[DEN_BITS+1]});
            valid_reg <= 1'b1;
            rx_reg    <= RT_IN'({39'({num_reg[NUM_BITS-2:0], ~rem_dif[DEN_BITS+1]}),
                                 {FRAC_BITS{1'b0}}});
            rrem_reg  <= '0;
            root_reg  <= '0;
            rstep_reg <= '0;
        end
        if (cmd.root_step) begin
            rx_reg    <= {rx_reg[RT_IN-3:0], 2'b00};
            rstep_reg <= rstep_reg + 1'b1;
            if (rt_sh >= rt_try) begin
                rrem_reg <= rt_sh - rt_try;
                root_reg <= {root_reg[22:0], 1'b1};
            end else begin
                rrem_reg <= rt_sh;
                root_reg <= {root_reg[22:0], 1'b0};
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            res_reg.count          <= 16'(cnt_reg);
            res_reg.total          <= 32'(s1_reg);
            res_reg.sum_of_squares <= 46'(s2_reg);
            res_reg.mean_q8        <= mean_reg;
            res_reg.variance_q8    <= var_reg;
            res_reg.std_dev_q8     <= root_reg;
            res_reg.minimum        <= 16'(lo_reg);
            res_reg.maximum        <= 16'(hi_reg);
            res_reg.variance_valid <= valid_reg;
            res_reg.dropped        <= drop_reg;
        end
    end

    assign out_word = res_reg;
endmodule
`default_nettype wire

FILE: hw/rtl/running_mean_variance_min_max.sv
// Running mean, variance, minimum and maximum of signed samples.
// A clear (count 0) skips the dividers; while the count is 1 the variance
// divider and square root are skipped; otherwise the result passes the 40-step
// mean divider, the 72-step variance divider and the 24-step square root.
// One word at a time: the next word is taken in the cycle after publish.
// aresetn is synchronous, active low, and clears the count, sums, minimum and maximum.
`timescale 1ns / 1ps
`default_nettype none
module running_mean_variance_min_max (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  rmv_pkg::rmv_in_t  s_data,
    output logic              m_valid,
    input  wire               m_ready,
    output rmv_pkg::rmv_out_t m_data
);
    import rmv_pkg::*;

    rmv_cmd_t cmd;
    rmv_sts_t sts;
    logic     busy;
    logic     m_valid_reg;

    assign s_ready = !busy;
    assign m_valid = m_valid_reg;

    // Output valid flag: set on publish, cleared when taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.publish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    rmv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_valid),
        .out_free (!m_valid_reg || m_ready),
        .sts      (sts),
        .busy     (busy),
        .cmd      (cmd)
    );

    rmv_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_word  (s_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_word (m_data)
    );
endmodule
`default_nettype wire

FILE: hw/rtl/rmv_checker.sv
// Port checker for the running statistics block, bound to the top level.
// Depends on rmv_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "running_mean_variance_min_max_assert.svh"
module rmv_checker (
    input wire               aclk,
    input wire               aresetn,
    input wire               s_valid,
    input wire               s_ready,
    input wire               m_valid,
    input wire               m_ready,
    input rmv_pkg::rmv_out_t m_data
);
    import rmv_pkg::*;

    // A result word holds until it is taken.
    `RMV_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    // One word in flight: no input is taken the cycle after one is.
    `RMV_ASSERT_NXT(a_single, aclk, aresetn, s_valid && s_ready, !s_ready)
    // A dropped sample only happens at a full count.
    `RMV_ASSERT_IMP(a_drop, aclk, aresetn, m_valid && m_data.dropped, m_data.count == '1)
    // Variance valid needs at least two samples.
    `RMV_ASSERT_IMP(a_vvalid, aclk, aresetn, m_valid && m_data.variance_valid,
                    m_data.count > 16'd1)
endmodule
bind running_mean_variance_min_max rmv_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
